// File: rtl/ospfdr_pkg.sv
`timescale 1ns / 1ps

package ospfdr_pkg;

  // Neighbor table depth
  localparam int NEIGHBORS = 16;
  localparam int IDX_W     = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  // Scan counter runs 0 .. NEIGHBORS+1 (table read latency plus local router)
  localparam int CNT_W     = $clog2(NEIGHBORS + 2);

  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int PRI_W    = 8;
  localparam int ID_W     = 32;
  localparam int STATE_W  = 3;
  localparam int IN_DW    = 144;
  localparam int OUT_DW   = 72;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  typedef enum logic [KIND_W-1:0] {
    EV_NBR_WRITE = 3'd0,
    EV_UP        = 3'd1,
    EV_WAIT      = 3'd2,
    EV_BACKUP    = 3'd3,
    EV_NBR_CHG   = 3'd4,
    EV_LOOP      = 3'd5,
    EV_UNLOOP    = 3'd6,
    EV_DOWN      = 3'd7
  } kind_e;

  typedef enum logic [STATE_W-1:0] {
    IF_DOWN     = 3'd0,
    IF_LOOPBACK = 3'd1,
    IF_WAITING  = 3'd2,
    IF_P2P      = 3'd3,
    IF_DROTHER  = 3'd4,
    IF_BACKUP   = 3'd5,
    IF_DR       = 3'd6
  } ifs_e;

  typedef enum logic [1:0] {
    CFG_PRIORITY  = 2'd0,
    CFG_ROUTER_ID = 2'd1,
    CFG_ADDRESS   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_SCAN1,
    SQ_RES1,
    SQ_SCAN2,
    SQ_RES2,
    SQ_EMIT
  } seq_e;

  // One neighbor table entry (valid bit kept apart in flops)
  typedef struct packed {
    logic             two_way;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  rid;
    logic [ID_W-1:0]  addr;
    logic [ID_W-1:0]  ddr;
    logic [ID_W-1:0]  dbdr;
  } nbr_t;

  typedef struct packed {
    logic             live;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  rid;
    logic [ID_W-1:0]  addr;
    logic [ID_W-1:0]  ddr;
    logic [ID_W-1:0]  dbdr;
  } cand_t;

  typedef struct packed {
    logic             found;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  rid;
    logic [ID_W-1:0]  addr;
  } best_t;

  // Priority first, router id second; ties keep the earlier one
  function automatic logic rank_above(input cand_t c, input best_t b);
    return {c.pri, c.rid} > {b.pri, b.rid};
  endfunction

endpackage

// File: rtl/ospf_interface_fsm_dr_election.sv
`timescale 1ns / 1ps

// OSPF interface state machine with DR/BDR election.
// Input beats (s_axis) carry a neighbor table write or an interface event
// (kind in tuser). Every input beat yields exactly one output beat (m_axis)
// with the interface state, DR, BDR and two status flags.
// The APB port sets local priority, router id and address; write it only
// while no beat is in flight.
// A table write or a plain event goes from accept through the emit state
// into the result register. An event that runs an election walks the table
// once (scan, result, emit); when no candidate declares itself DR a second
// walk (scan, result) picks the BDR before the emit state.
// The next beat is taken in the cycle after the result register is loaded.
// The walk reads one table entry per cycle from the entry memory and feeds it
// to one set of running-best comparators; that walk sets the rate.
// s_axis_tready is high only while the sequencer is idle; a result waiting in
// the output register does not block acceptance, but the next result waits
// until the receiver takes the previous one.
// Reset: interface down, DR/BDR zero, all table entries invalid, priority 1.

module ospf_interface_fsm_dr_election (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slot[3:0], entry_valid[4], entry_two_way[5], entry_priority[13:6],
  // entry_router_id[45:14], entry_address[77:46], entry_declared_dr[109:78],
  // entry_declared_bdr[141:110], zero pad
  input  logic [ospfdr_pkg::IN_DW-1:0]  s_axis_tdata,
  // kind[2:0]
  input  logic [ospfdr_pkg::KIND_W-1:0] s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // iface_state[2:0], current_dr[34:3], current_bdr[66:35],
  // state_changed[67], election_ran[68], zero pad
  output logic [ospfdr_pkg::OUT_DW-1:0] m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ospfdr_pkg::CFG_AW-1:0] paddr,
  input  logic [ospfdr_pkg::CFG_DW-1:0] pwdata,
  output logic [ospfdr_pkg::CFG_DW-1:0] prdata,
  output logic                          pready
);
  import ospfdr_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST_NBR = CNT_W'(NEIGHBORS);
  localparam logic [CNT_W-1:0] CNT_LOCAL    = CNT_W'(NEIGHBORS + 1);

  // ---------------- configuration ----------------
  logic [PRI_W-1:0] loc_pri_q;
  logic [ID_W-1:0]  loc_rid_q, loc_addr_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_pri_q  <= PRI_W'(1);
      loc_rid_q  <= '0;
      loc_addr_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx_e'(paddr[3:2]))
        CFG_PRIORITY:  loc_pri_q  <= pwdata[PRI_W-1:0];
        CFG_ROUTER_ID: loc_rid_q  <= pwdata;
        CFG_ADDRESS:   loc_addr_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_e'(paddr[3:2]))
      CFG_PRIORITY:  prdata = {{(CFG_DW-PRI_W){1'b0}}, loc_pri_q};
      CFG_ROUTER_ID: prdata = loc_rid_q;
      CFG_ADDRESS:   prdata = loc_addr_q;
      default:       prdata = '0;
    endcase
  end

  // ---------------- input beat fields ----------------
  kind_e            in_kind;
  logic [SLOT_W-1:0] in_slot;
  logic             in_valid, s_acc, slot_ok;
  nbr_t             in_ent;

  assign in_kind          = kind_e'(s_axis_tuser);
  assign in_slot          = s_axis_tdata[3:0];
  assign in_valid         = s_axis_tdata[4];
  assign in_ent.two_way   = s_axis_tdata[5];
  assign in_ent.pri       = s_axis_tdata[13:6];
  assign in_ent.rid       = s_axis_tdata[45:14];
  assign in_ent.addr      = s_axis_tdata[77:46];
  assign in_ent.ddr       = s_axis_tdata[109:78];
  assign in_ent.dbdr      = s_axis_tdata[141:110];
  assign slot_ok          = {5'd0, in_slot} < 9'(NEIGHBORS);
  assign s_acc            = s_axis_tvalid && s_axis_tready;

  // ---------------- sequencer state ----------------
  seq_e             sq_q, sq_d;
  ifs_e             ifs_q, ifs_d, before_q, before_d;
  logic [ID_W-1:0]  dr_q, dr_d, bdr_q, bdr_d, edr_q, edr_d;
  logic             ran_q, ran_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NEIGHBORS-1:0] nbr_vld_q;

  // Entry memory, one registered read port walked by the counter
  nbr_t             nbr_mem [NEIGHBORS];
  nbr_t             rd_q;
  logic             rd_v_q;
  logic             scanning;
  logic [IDX_W-1:0] rd_idx;

  assign scanning = (sq_q == SQ_SCAN1) || (sq_q == SQ_SCAN2);
  assign rd_idx   = cnt_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (s_acc && in_kind == EV_NBR_WRITE && slot_ok && in_valid) begin
      nbr_mem[IDX_W'(in_slot)] <= in_ent;
    end
    rd_q <= nbr_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbr_vld_q <= '0;
      rd_v_q    <= 1'b0;
    end else begin
      rd_v_q <= scanning && (cnt_q < CNT_LAST_NBR) && nbr_vld_q[rd_idx];
      if (s_acc && in_kind == EV_DOWN) begin
        nbr_vld_q <= '0;
      end else if (s_acc && in_kind == EV_NBR_WRITE && slot_ok) begin
        nbr_vld_q[IDX_W'(in_slot)] <= in_valid;
      end
    end
  end

  // ---------------- candidate and running-best trackers ----------------
  cand_t cand;
  logic  cand_self_dr, cand_self_bdr;
  logic  q0, q1, q2;
  best_t trk0_q, trk1_q, trk2_q, trk0_d, trk1_d, trk2_d;

  always_comb begin
    if (cnt_q == CNT_LOCAL) begin
      cand.live = (loc_pri_q != '0);
      cand.pri  = loc_pri_q;
      cand.rid  = loc_rid_q;
      cand.addr = loc_addr_q;
      cand.ddr  = dr_q;
      cand.dbdr = bdr_q;
    end else begin
      cand.live = rd_v_q && rd_q.two_way && (rd_q.pri != '0);
      cand.pri  = rd_q.pri;
      cand.rid  = rd_q.rid;
      cand.addr = rd_q.addr;
      cand.ddr  = rd_q.ddr;
      cand.dbdr = rd_q.dbdr;
    end
  end

  assign cand_self_dr  = (cand.ddr == cand.addr);
  assign cand_self_bdr = (cand.dbdr == cand.addr);
  // tracker 0: self-declared BDR on walk 1, any address but the new DR on walk 2
  assign q0 = cand.live && ((sq_q == SQ_SCAN2) ? (cand.addr != edr_q)
                                               : (!cand_self_dr && cand_self_bdr));
  assign q1 = cand.live && (sq_q == SQ_SCAN1) && !cand_self_dr;
  assign q2 = cand.live && (sq_q == SQ_SCAN1) && cand_self_dr;

  always_comb begin
    trk0_d = trk0_q;
    trk1_d = trk1_q;
    trk2_d = trk2_q;
    if (scanning) begin
      if (q0 && (!trk0_q.found || rank_above(cand, trk0_q))) begin
        trk0_d = '{found: 1'b1, pri: cand.pri, rid: cand.rid, addr: cand.addr};
      end
      if (q1 && (!trk1_q.found || rank_above(cand, trk1_q))) begin
        trk1_d = '{found: 1'b1, pri: cand.pri, rid: cand.rid, addr: cand.addr};
      end
      if (q2 && (!trk2_q.found || rank_above(cand, trk2_q))) begin
        trk2_d = '{found: 1'b1, pri: cand.pri, rid: cand.rid, addr: cand.addr};
      end
    end
    // start of a walk clears all three trackers
    if (sq_q == SQ_IDLE || sq_q == SQ_RES1) begin
      trk0_d.found = 1'b0;
      trk1_d.found = 1'b0;
      trk2_d.found = 1'b0;
    end
  end

  // ---------------- result of walk 1 ----------------
  logic [ID_W-1:0] bdr_first, bdr_any, dr_self;
  assign bdr_any   = trk1_q.found ? trk1_q.addr : '0;
  assign bdr_first = (trk0_q.found && trk0_q.addr != '0) ? trk0_q.addr : bdr_any;
  assign dr_self   = trk2_q.found ? trk2_q.addr : '0;

  function automatic ifs_e role_of(input logic [ID_W-1:0] me,
                                   input logic [ID_W-1:0] dr,
                                   input logic [ID_W-1:0] bdr);
    if (me == dr) return IF_DR;
    else if (me == bdr) return IF_BACKUP;
    else return IF_DROTHER;
  endfunction

  // ---------------- output register ----------------
  logic             m_vld_q;
  ifs_e             m_st_q;
  logic [ID_W-1:0]  m_dr_q, m_bdr_q;
  logic             m_chg_q, m_ran_q;
  logic             emit;

  assign emit = (sq_q == SQ_EMIT) && (!m_vld_q || m_axis_tready);

  // ---------------- next state ----------------
  always_comb begin
    sq_d     = sq_q;
    ifs_d    = ifs_q;
    before_d = before_q;
    dr_d     = dr_q;
    bdr_d    = bdr_q;
    edr_d    = edr_q;
    ran_d    = ran_q;
    cnt_d    = '0;
    s_axis_tready = (sq_q == SQ_IDLE);
    unique case (sq_q)
      SQ_IDLE: begin
        if (s_axis_tvalid) begin
          before_d = ifs_q;
          ran_d    = 1'b0;
          sq_d     = SQ_EMIT;
          case (in_kind)
            EV_UP:     ifs_d = (loc_pri_q == '0) ? IF_DROTHER : IF_WAITING;
            EV_WAIT, EV_BACKUP: begin
              if (ifs_q == IF_WAITING) begin
                ran_d = 1'b1;
                sq_d  = SQ_SCAN1;
              end
            end
            EV_NBR_CHG: begin
              if (ifs_q >= IF_DROTHER) begin
                ran_d = 1'b1;
                sq_d  = SQ_SCAN1;
              end
            end
            EV_LOOP:   ifs_d = IF_LOOPBACK;
            EV_UNLOOP: ifs_d = IF_DOWN;
            EV_DOWN:   ifs_d = IF_DOWN;
            default: ;
          endcase
        end
      end
      SQ_SCAN1, SQ_SCAN2: begin
        if (cnt_q == CNT_LOCAL) begin
          sq_d = (sq_q == SQ_SCAN1) ? SQ_RES1 : SQ_RES2;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      SQ_RES1: begin
        if (dr_self == '0) begin
          edr_d = bdr_first;
          sq_d  = SQ_SCAN2;
        end else begin
          dr_d  = dr_self;
          bdr_d = bdr_first;
          ifs_d = role_of(loc_addr_q, dr_self, bdr_first);
          sq_d  = SQ_EMIT;
        end
      end
      SQ_RES2: begin
        dr_d  = edr_q;
        bdr_d = trk0_q.found ? trk0_q.addr : '0;
        ifs_d = role_of(loc_addr_q, edr_q, bdr_d);
        sq_d  = SQ_EMIT;
      end
      SQ_EMIT: begin
        if (emit) sq_d = SQ_IDLE;
      end
      default: sq_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q     <= SQ_IDLE;
      ifs_q    <= IF_DOWN;
      before_q <= IF_DOWN;
      dr_q     <= '0;
      bdr_q    <= '0;
      ran_q    <= 1'b0;
      cnt_q    <= '0;
      m_vld_q  <= 1'b0;
    end else begin
      sq_q     <= sq_d;
      ifs_q    <= ifs_d;
      before_q <= before_d;
      dr_q     <= dr_d;
      bdr_q    <= bdr_d;
      ran_q    <= ran_d;
      cnt_q    <= cnt_d;
      if (emit) m_vld_q <= 1'b1;
      else if (m_axis_tready) m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    edr_q  <= edr_d;
    trk0_q <= trk0_d;
    trk1_q <= trk1_d;
    trk2_q <= trk2_d;
    if (emit) begin
      m_st_q  <= ifs_q;
      m_dr_q  <= dr_q;
      m_bdr_q <= bdr_q;
      m_chg_q <= (ifs_q != before_q);
      m_ran_q <= ran_q;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {3'b000, m_ran_q, m_chg_q, m_bdr_q, m_dr_q, m_st_q};

  // ---------------- assertions ----------------
  a_down_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
      s_acc && in_kind == EV_DOWN |=> nbr_vld_q == '0)
    else $error("down event left table entries valid");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
      s_acc |=> !s_axis_tready)
    else $error("accepted a beat while the previous one is in work");

  a_ran_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_vld_q && m_ran_q |->
        (m_st_q == IF_DR || m_st_q == IF_BACKUP || m_st_q == IF_DROTHER))
    else $error("election result without a DR, Backup or DROther state");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q <= CNT_LOCAL)
    else $error("scan counter past the local router step");

  a_scan_only_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !scanning |=> cnt_q == '0)
    else $error("scan counter moved outside a table walk");

endmodule
